// ===== rtl/spool_pkg.sv =====
// Shared types and codes for the slot pool with ordered active list.
// No dependencies; imported by the datapath, controller and top level.
`default_nettype none
package spool_pkg;
    localparam int DefNumSlots = 32;

    localparam logic [2:0] MODE_ALLOC = 3'd0;
    localparam logic [2:0] MODE_FREE  = 3'd1;
    localparam logic [2:0] MODE_CLEAR = 3'd2;
    localparam logic [2:0] MODE_MOVE  = 3'd3;
    localparam logic [2:0] MODE_FIND  = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_INACTIVE = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    // Datapath operation codes issued by the controller.
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_LOAD      = 4'd1;  // capture request
    localparam logic [3:0] OP_RD_SLOT   = 4'd2;  // read links of request slot
    localparam logic [3:0] OP_RD_FREE   = 4'd3;  // read links of free head
    localparam logic [3:0] OP_ALLOC     = 4'd4;  // append free head to tail
    localparam logic [3:0] OP_UNLINK    = 4'd5;  // patch neighbor next / head
    localparam logic [3:0] OP_UNLINK2   = 4'd6;  // patch neighbor prev / tail
    localparam logic [3:0] OP_RELEASE   = 4'd7;  // push cursor slot on free list
    localparam logic [3:0] OP_HEAD_FIX  = 4'd8;  // prev of old head := slot
    localparam logic [3:0] OP_MOVE_SET  = 4'd9;  // slot becomes head
    localparam logic [3:0] OP_CUR_HEAD  = 4'd10; // cursor := active head
    localparam logic [3:0] OP_RD_CUR    = 4'd11; // read links and id of cursor
    localparam logic [3:0] OP_ADVANCE   = 4'd12; // cursor := next of cursor

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] status;
        logic       set_status;
        logic       out_load;
    } spool_cmd_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       slot_ok;     // request slot exists and is active
        logic       free_avail;
        logic       has_prev;    // request slot has a predecessor
        logic       cur_valid;   // cursor points at a slot
        logic       id_match;
        logic       steps_done;
    } spool_stat_t;
endpackage
`default_nettype wire

// ===== rtl/spool_datapath.sv =====
// Datapath: link memories, list pointers, id memory and result register.
// Depends on spool_pkg; driven by spool_ctrl commands.
`default_nettype none
module spool_datapath
    import spool_pkg::*;
#(
    parameter int NUM_SLOTS = DefNumSlots,
    localparam int LW = $clog2(NUM_SLOTS + 1),
    localparam int IW = $clog2(NUM_SLOTS)
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire spool_cmd_t  cmd,
    output spool_stat_t      stat,
    input  wire logic [2:0]  in_mode,
    input  wire logic [4:0]  in_slot,
    input  wire logic [31:0] in_search_id,
    output logic [4:0]       res_slot,
    output logic [1:0]       res_status,
    output logic [31:0]      res_id,
    output logic [5:0]       res_count
);
    localparam logic [LW-1:0] NIL = LW'(NUM_SLOTS);

    logic [LW-1:0] next_mem [NUM_SLOTS];
    logic [LW-1:0] prev_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] act_reg;
    logic [NUM_SLOTS-1:0] nvalid_reg; // next_mem entry written since reset
    logic [NUM_SLOTS-1:0] pvalid_reg;
    logic [31:0] id_mem [NUM_SLOTS];

    logic [LW-1:0] free_head_reg, act_head_reg, act_tail_reg, cur_reg;
    logic [LW-1:0] rd_next_reg, rd_prev_reg;
    logic [31:0]   rd_id_reg, seq_reg, sid_reg;
    logic [2:0]    mode_reg;
    logic [LW-1:0] slot_reg;
    logic [LW:0]   count_reg;
    logic [LW:0]   steps_reg;
    logic [1:0]    status_reg;
    logic [4:0]    res_slot_reg;
    logic [31:0]   res_id_reg;
    logic [1:0]    res_status_reg;
    logic [5:0]    res_count_reg;

    logic [LW-1:0] raddr;
    logic [IW-1:0] ri, ci, si, fi;
    logic          wr_n, wr_p;
    logic [IW-1:0] wa_n, wa_p;
    logic [LW-1:0] wd_n, wd_p;
    logic [NUM_SLOTS-1:0] act_set, act_clr;

    function automatic logic is_s(input logic [LW-1:0] v);
        return v < NIL;
    endfunction

    assign ci = cur_reg[IW-1:0];
    assign si = slot_reg[IW-1:0];
    assign fi = free_head_reg[IW-1:0];

    always_comb begin
        case (cmd.op)
            OP_RD_SLOT: raddr = slot_reg;
            OP_RD_FREE: raddr = free_head_reg;
            default:    raddr = cur_reg;
        endcase
    end
    assign ri = raddr[IW-1:0];

    // Link memory write ports: at most one next and one prev write; OP_ALLOC also writes the new slot's own links.
    always_comb begin
        wr_n = 1'b0; wa_n = '0; wd_n = NIL;
        wr_p = 1'b0; wa_p = '0; wd_p = NIL;
        case (cmd.op)
            OP_ALLOC: begin
                if (is_s(rd_next_reg)) begin
                    wr_p = 1'b1; wa_p = rd_next_reg[IW-1:0]; wd_p = NIL;
                end
                if (is_s(act_tail_reg)) begin
                    wr_n = 1'b1; wa_n = act_tail_reg[IW-1:0]; wd_n = free_head_reg;
                end
            end
            OP_UNLINK: begin
                if (is_s(rd_prev_reg)) begin
                    wr_n = 1'b1; wa_n = rd_prev_reg[IW-1:0]; wd_n = rd_next_reg;
                end
            end
            OP_UNLINK2: begin
                if (is_s(rd_next_reg)) begin
                    wr_p = 1'b1; wa_p = rd_next_reg[IW-1:0]; wd_p = rd_prev_reg;
                end
            end
            OP_RELEASE: begin
                wr_n = 1'b1; wa_n = ci; wd_n = free_head_reg;
                wr_p = 1'b1; wa_p = ci; wd_p = NIL;
            end
            OP_HEAD_FIX: begin
                if (is_s(act_head_reg)) begin
                    wr_p = 1'b1; wa_p = act_head_reg[IW-1:0]; wd_p = slot_reg;
                end
            end
            OP_MOVE_SET: begin
                wr_n = 1'b1; wa_n = si; wd_n = act_head_reg;
                wr_p = 1'b1; wa_p = si; wd_p = NIL;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_n) next_mem[wa_n] <= wd_n;
        if (wr_p) prev_mem[wa_p] <= wd_p;
        if (cmd.op == OP_ALLOC) begin
            id_mem[fi] <= seq_reg;
            prev_mem[fi] <= act_tail_reg;
            // new tail ends the active list
            next_mem[fi] <= NIL;
        end
        rd_id_reg <= id_mem[ri];
    end

    // Reset image of links: next = i+1 (nil for last), prev = nil.
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_RD_SLOT || cmd.op == OP_RD_FREE || cmd.op == OP_RD_CUR) begin
            rd_next_reg <= nvalid_reg[ri] ? next_mem[ri] : LW'(raddr + LW'(1));
            rd_prev_reg <= pvalid_reg[ri] ? prev_mem[ri] : NIL;
        end
    end

    always_comb begin
        act_set = '0;
        act_clr = '0;
        if (cmd.op == OP_ALLOC) act_set[fi] = 1'b1;
        if (cmd.op == OP_RELEASE) act_clr[ci] = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg       <= '0;
            nvalid_reg    <= '0;
            pvalid_reg    <= '0;
            free_head_reg <= '0;
            act_head_reg  <= NIL;
            act_tail_reg  <= NIL;
            count_reg     <= '0;
            seq_reg       <= '0;
            status_reg    <= ST_OK;
            cur_reg       <= NIL;
            steps_reg     <= '0;
            mode_reg      <= MODE_ALLOC;
            slot_reg      <= '0;
        end else begin
            act_reg <= (act_reg | act_set) & ~act_clr;
            if (wr_n) nvalid_reg[wa_n] <= 1'b1;
            if (wr_p) pvalid_reg[wa_p] <= 1'b1;
            if (cmd.op == OP_ALLOC) begin
                nvalid_reg[fi] <= 1'b1;
                pvalid_reg[fi] <= 1'b1;
            end
            if (cmd.set_status) status_reg <= cmd.status;
            case (cmd.op)
                OP_LOAD: begin
                    mode_reg  <= in_mode;
                    slot_reg  <= LW'(in_slot);
                    cur_reg   <= LW'(in_slot);
                    steps_reg <= '0;
                end
                OP_ALLOC: begin
                    free_head_reg <= rd_next_reg;
                    if (!is_s(act_tail_reg)) act_head_reg <= free_head_reg;
                    act_tail_reg <= free_head_reg;
                    cur_reg      <= free_head_reg;
                    seq_reg      <= seq_reg + 32'd1;
                    count_reg    <= count_reg + 1'b1;
                end
                OP_UNLINK: if (!is_s(rd_prev_reg)) act_head_reg <= rd_next_reg;
                OP_UNLINK2: if (!is_s(rd_next_reg)) act_tail_reg <= rd_prev_reg;
                OP_RELEASE: begin
                    free_head_reg <= cur_reg;
                    if (count_reg != '0) count_reg <= count_reg - 1'b1;
                end
                OP_MOVE_SET: begin
                    act_head_reg <= slot_reg;
                    if (!is_s(act_tail_reg)) act_tail_reg <= slot_reg;
                end
                OP_CUR_HEAD: cur_reg <= act_head_reg;
                OP_ADVANCE: begin
                    cur_reg   <= rd_next_reg;
                    steps_reg <= steps_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_LOAD) sid_reg <= in_search_id;
    end

    // Result register: slot and id are zeroed unless status is ok.
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            res_slot_reg   <= '0;
            res_id_reg     <= '0;
            res_status_reg <= status_reg;
            res_count_reg  <= 6'(count_reg);
            if (status_reg == ST_OK) begin
                case (mode_reg)
                    MODE_ALLOC: begin
                        res_slot_reg <= 5'(cur_reg);
                        res_id_reg   <= seq_reg - 32'd1;
                    end
                    MODE_FREE, MODE_MOVE: res_slot_reg <= 5'(slot_reg);
                    MODE_FIND: begin
                        res_slot_reg <= 5'(cur_reg);
                        res_id_reg   <= rd_id_reg;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign stat.mode       = mode_reg;
    assign stat.slot_ok    = is_s(slot_reg) && act_reg[si];
    assign stat.free_avail = is_s(free_head_reg);
    assign stat.has_prev   = is_s(rd_prev_reg);
    assign stat.cur_valid  = is_s(cur_reg);
    assign stat.id_match   = rd_id_reg == sid_reg;
    assign stat.steps_done = steps_reg >= (LW+1)'(NUM_SLOTS);

    assign res_slot   = res_slot_reg;
    assign res_status = res_status_reg;
    assign res_id     = res_id_reg;
    assign res_count  = res_count_reg;
endmodule
`default_nettype wire

// ===== rtl/spool_ctrl.sv =====
// Controller: sequences memory accesses per request and handles the handshake.
// Depends on spool_pkg; commands spool_datapath.
`default_nettype none
module spool_ctrl
    import spool_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    input  wire spool_stat_t stat,
    output spool_cmd_t       cmd
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_AL_RD  = 4'd2;
    localparam logic [3:0] S_AL_WR  = 4'd3;
    localparam logic [3:0] S_UN_RD  = 4'd4;
    localparam logic [3:0] S_UN_1   = 4'd5;
    localparam logic [3:0] S_UN_2   = 4'd6;
    localparam logic [3:0] S_FR     = 4'd7;
    localparam logic [3:0] S_MV_1   = 4'd8;
    localparam logic [3:0] S_MV_2   = 4'd9;
    localparam logic [3:0] S_WALK   = 4'd10;
    localparam logic [3:0] S_WRD    = 4'd11;
    localparam logic [3:0] S_WCHK   = 4'd12;
    localparam logic [3:0] S_DONE   = 4'd13;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '{op: OP_NONE, status: ST_OK, set_status: 1'b0, out_load: 1'b0};
        if (out_valid_reg && out_ready) out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE: if (in_valid) begin
                cmd.op = OP_LOAD; cmd.set_status = 1'b1; cmd.status = ST_OK;
                state_next = S_DISP;
            end
            S_DISP: begin
                case (stat.mode)
                    MODE_ALLOC: if (stat.free_avail) begin
                        cmd.op = OP_RD_FREE; state_next = S_AL_RD;
                    end else begin
                        cmd.set_status = 1'b1; cmd.status = ST_FULL; state_next = S_DONE;
                    end
                    MODE_FREE, MODE_MOVE: if (stat.slot_ok) begin
                        cmd.op = OP_RD_SLOT; state_next = S_UN_RD;
                    end else begin
                        cmd.set_status = 1'b1; cmd.status = ST_INACTIVE;
                        state_next = S_DONE;
                    end
                    MODE_CLEAR: begin
                        cmd.op = OP_CUR_HEAD; state_next = S_WALK;
                    end
                    MODE_FIND: begin
                        cmd.op = OP_CUR_HEAD; cmd.set_status = 1'b1;
                        cmd.status = ST_NOTFOUND; state_next = S_WALK;
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_AL_RD: begin cmd.op = OP_ALLOC; state_next = S_DONE; end
            S_UN_RD: begin
                // move of the head slot changes nothing
                if (stat.mode == MODE_MOVE && !stat.has_prev) state_next = S_DONE;
                else state_next = S_UN_1;
            end
            S_UN_1: begin cmd.op = OP_UNLINK; state_next = S_UN_2; end
            S_UN_2: begin
                cmd.op = OP_UNLINK2;
                state_next = (stat.mode == MODE_MOVE) ? S_MV_1 : S_FR;
            end
            S_FR: begin
                cmd.op = OP_RELEASE;
                state_next = (stat.mode == MODE_CLEAR) ? S_WCHK : S_DONE;
            end
            S_MV_1: begin cmd.op = OP_HEAD_FIX; state_next = S_MV_2; end
            S_MV_2: begin cmd.op = OP_MOVE_SET; state_next = S_DONE; end
            S_WALK: begin
                if (!stat.cur_valid || stat.steps_done) state_next = S_DONE;
                else begin cmd.op = OP_RD_CUR; state_next = S_WRD; end
            end
            S_WRD: begin
                if (stat.mode == MODE_CLEAR) state_next = S_UN_1;
                else if (stat.id_match) begin
                    cmd.set_status = 1'b1; cmd.status = ST_OK; state_next = S_DONE;
                end else begin
                    cmd.op = OP_ADVANCE; state_next = S_WALK;
                end
            end
            // release left cursor links in rd_next_reg: advance along them
            S_WCHK: begin cmd.op = OP_ADVANCE; state_next = S_WALK; end
            // hold until the previous result has left the output register
            S_DONE: if (!out_valid_reg || out_ready) begin
                cmd.out_load = 1'b1; out_valid_next = 1'b1; state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;
endmodule
`default_nettype wire

// ===== rtl/slot_pool_with_ordered_active_list.sv =====
// Top level of the slot pool: stream ports around controller and datapath.
// Depends on spool_pkg, spool_ctrl and spool_datapath.
`default_nettype none
// Handles one request at a time. Allocate reads the free head, then appends
// it to the tail; free reads the slot, unlinks it and releases it; move
// unlinks the slot, fixes the old head and makes it head (the head slot is
// left as is); full pool, inactive slot or unused mode skip to the result;
// find and free all walk from the head. Each step is one access to the link
// memories. Result is registered, so the next request is taken while the
// previous result waits; it then holds before its own result until the
// waiting one is taken. No clearing pass after reset.
module slot_pool_with_ordered_active_list
    import spool_pkg::*;
#(
    parameter int NUM_SLOTS = DefNumSlots
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // mode[2:0], slot[7:3], search_id[39:8]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata   // result_slot[4:0], status[6:5],
                                       // assigned_id[38:7], live_count[44:39]
);
    spool_cmd_t  cmd;
    spool_stat_t stat;
    logic [4:0]  res_slot;
    logic [1:0]  res_status;
    logic [31:0] res_id;
    logic [5:0]  res_count;

    spool_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .stat(stat), .cmd(cmd)
    );

    spool_datapath #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .in_mode(s_tdata[2:0]), .in_slot(s_tdata[7:3]),
        .in_search_id(s_tdata[39:8]),
        .res_slot(res_slot), .res_status(res_status),
        .res_id(res_id), .res_count(res_count)
    );

    assign m_tdata = {3'b000, res_count, res_id, res_status, res_slot};
endmodule
`default_nettype wire
